@@ rtl/core/bsps_pkg.sv @@
// Shared types and constants of the bus servo packet scheduler.
`timescale 1ns / 1ps
`default_nettype none

package bsps_pkg;

   // Item kinds on the request channel.
   typedef enum logic [1:0] {
      CMD_REGISTER = 2'd0,
      CMD_UPDATE   = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SERVO_ID_0    = 3'd0;
   localparam logic [2:0] CSR_SERVO_ID_1    = 3'd1;
   localparam logic [2:0] CSR_SERVO_ID_2    = 3'd2;
   localparam logic [2:0] CSR_SERVO_ID_3    = 3'd3;
   localparam logic [2:0] CSR_SEND_INTERVAL = 3'd4;
   localparam logic [2:0] CSR_REFRESH_INTV  = 3'd5;
   localparam logic [2:0] CSR_MOVE_CMD      = 3'd6;

   localparam int unsigned SERVO_IDS = 4;

   // Configuration reset values.
   localparam logic [15:0] SEND_INTERVAL_RESET = 16'd10;
   localparam logic [15:0] REFRESH_INTV_RESET  = 16'd500;
   localparam logic [7:0]  MOVE_CMD_RESET      = 8'd1;

   // Packet framing.
   localparam logic [7:0] HEADER_BYTE   = 8'h55;
   localparam logic [7:0] LOAD_CMD      = 8'd31;
   localparam logic [7:0] LOAD_PARAM    = 8'd1;
   localparam logic [7:0] LOAD_LEN      = 8'd4;
   localparam logic [7:0] MOVE_LEN      = 8'd7;
   localparam logic [3:0] LOAD_BYTES    = 4'd7;
   localparam logic [3:0] MOVE_BYTES    = 4'd10;

   // Depth of the job queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  slot;
      logic [15:0] position;
      logic [15:0] move_time;
      logic        enabled;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [3:0] packet_bytes;
      logic [7:0] byte_0;
      logic [7:0] byte_1;
      logic [7:0] byte_2;
      logic [7:0] byte_3;
      logic [7:0] byte_4;
      logic [7:0] byte_5;
      logic [7:0] byte_6;
      logic [7:0] byte_7;
      logic [7:0] byte_8;
      logic [7:0] byte_9;
      logic       last_packet;
   } rsp_type;

   typedef struct packed {
      logic [SERVO_IDS-1:0][7:0] servo_id;
      logic [15:0]               send_interval;
      logic [15:0]               refresh_interval;
      logic [7:0]                move_cmd;
   } cfg_type;

   // One packet to be built by the back end.
   typedef struct packed {
      logic        is_load;
      logic [7:0]  servo_id;
      logic [15:0] position;
      logic [15:0] move_time;
      logic        last;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } front_state_type;

endpackage

`default_nettype wire

@@ rtl/core/bsps_queue.sv @@
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module bsps_queue
   import bsps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_data,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_data,
   output logic         empty
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("job queue count above depth");

endmodule

`default_nettype wire

@@ rtl/core/bsps_front.sv @@
// Front end: accepts items, keeps the slot table and issues packet jobs.
`timescale 1ns / 1ps
`default_nettype none

module bsps_front
   import bsps_pkg::*;
#(
   parameter int unsigned SLOTS = 4
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  req_type      req_data,
   output logic         req_full,
   input  cfg_type      cfg,
   output logic         job_push,
   output job_type      job_data,
   input  wire logic    job_full
);

   localparam int unsigned CNT_W = $clog2(SLOTS + 1);
   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   front_state_type  state_ff, state_in;
   logic [CNT_W-1:0] slot_count_ff, slot_count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] end_ff, end_in;
   logic             refresh_ff, refresh_in;
   logic             phase_ff, phase_in;
   logic [31:0]      last_send_ff, last_send_in;
   logic [31:0]      last_refresh_ff, last_refresh_in;

   logic             enabled_ff [SLOTS];
   logic [15:0]      position_ff [SLOTS];
   logic [15:0]      move_time_ff [SLOTS];

   logic             accept;
   logic             tab_write;
   logic [IDX_W-1:0] tab_index;
   logic [31:0]      send_elapsed, refresh_elapsed;
   logic             send_due, refresh_due;
   logic             table_full;
   logic             later_enabled;
   logic [IDX_W-1:0] cur;

   assign req_full        = (state_ff != ST_IDLE);
   assign accept          = req_push && !req_full;
   assign table_full      = (slot_count_ff == CNT_W'(SLOTS));
   assign send_elapsed    = req_data.now_ms - last_send_ff;
   assign refresh_elapsed = req_data.now_ms - last_refresh_ff;
   assign send_due        = (send_elapsed >= {16'd0, cfg.send_interval});
   assign refresh_due     = (refresh_elapsed >= {16'd0, cfg.refresh_interval});
   assign cur             = idx_ff[IDX_W-1:0];

   // An enabled slot after the current one still owes a move packet.
   always_comb begin
      later_enabled = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if ((CNT_W'(j) > idx_ff) && (CNT_W'(j) < end_ff) && enabled_ff[j]) begin
            later_enabled = 1'b1;
         end
      end
   end

   // Item decode and the slot walk.
   always_comb begin
      state_in        = state_ff;
      slot_count_in   = slot_count_ff;
      idx_in          = idx_ff;
      end_in          = end_ff;
      refresh_in      = refresh_ff;
      phase_in        = phase_ff;
      last_send_in    = last_send_ff;
      last_refresh_in = last_refresh_ff;
      tab_write       = 1'b0;
      tab_index       = req_data.slot[IDX_W-1:0];
      job_push        = 1'b0;
      job_data.is_load  = 1'b0;
      job_data.servo_id = cfg.servo_id[2'(cur)];
      job_data.position = position_ff[cur];
      job_data.move_time = move_time_ff[cur];
      job_data.last     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_data.cmd))
                  CMD_REGISTER: begin
                     if (!table_full) begin
                        tab_write     = 1'b1;
                        tab_index     = slot_count_ff[IDX_W-1:0];
                        slot_count_in = slot_count_ff + 1'b1;
                        if (req_data.enabled) begin
                           idx_in     = slot_count_ff;
                           end_in     = slot_count_ff + 1'b1;
                           refresh_in = 1'b1;
                           phase_in   = 1'b0;
                           state_in   = ST_WALK;
                        end
                     end
                  end
                  CMD_UPDATE: begin
                     if (3'(req_data.slot) < 3'(slot_count_ff)) begin
                        tab_write = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     if (send_due) begin
                        last_send_in = req_data.now_ms;
                        if (refresh_due) begin
                           last_refresh_in = req_data.now_ms;
                        end
                        idx_in     = '0;
                        end_in     = slot_count_ff;
                        refresh_in = refresh_due;
                        phase_in   = 1'b0;
                        state_in   = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (idx_ff >= end_ff) begin
               state_in = ST_IDLE;
            end else if (!enabled_ff[cur]) begin
               idx_in = idx_ff + 1'b1;
            end else if (!job_full) begin
               job_push = 1'b1;
               if (refresh_ff && !phase_ff) begin
                  job_data.is_load = 1'b1;
                  phase_in         = 1'b1;
               end else begin
                  job_data.last = !later_enabled;
                  phase_in      = 1'b0;
                  idx_in        = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         slot_count_ff   <= '0;
         idx_ff          <= '0;
         end_ff          <= '0;
         refresh_ff      <= 1'b0;
         phase_ff        <= 1'b0;
         last_send_ff    <= '0;
         last_refresh_ff <= '0;
      end else begin
         state_ff        <= state_in;
         slot_count_ff   <= slot_count_in;
         idx_ff          <= idx_in;
         end_ff          <= end_in;
         refresh_ff      <= refresh_in;
         phase_ff        <= phase_in;
         last_send_ff    <= last_send_in;
         last_refresh_ff <= last_refresh_in;
      end
   end

   // Enable flags are cleared by reset; the rest of the table is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SLOTS; j++) begin
            enabled_ff[j] <= 1'b0;
         end
      end else if (tab_write) begin
         enabled_ff[tab_index] <= req_data.enabled;
      end
   end

   always_ff @(posedge clock) begin
      if (tab_write) begin
         position_ff[tab_index]  <= req_data.position;
         move_time_ff[tab_index] <= req_data.move_time;
      end
   end

   a_idle_no_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !job_push)
      else $error("job issued while front end idle");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idx_ff <= end_ff) && (end_ff <= CNT_W'(SLOTS)))
      else $error("slot walk out of range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      slot_count_ff <= CNT_W'(SLOTS))
      else $error("slot count above capacity");

endmodule

`default_nettype wire

@@ rtl/core/bsps_back.sv @@
// Back end: turns jobs into framed packets in the result register.
`timescale 1ns / 1ps
`default_nettype none

module bsps_back
   import bsps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  job_type      job_data,
   input  wire logic    job_empty,
   output logic         job_pop,
   input  cfg_type      cfg,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    room;
   logic [7:0] load_sum, move_sum;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;
   assign room      = !valid_ff || rsp_pop;
   assign job_pop   = room && !job_empty;

   // Checksums wrap at eight bits.
   assign load_sum = job_data.servo_id + LOAD_LEN + LOAD_CMD + LOAD_PARAM;
   assign move_sum = job_data.servo_id + MOVE_LEN + cfg.move_cmd
                   + job_data.position[7:0] + job_data.position[15:8]
                   + job_data.move_time[7:0] + job_data.move_time[15:8];

   // Packet framing for both packet kinds.
   always_comb begin
      rsp_in.byte_0      = HEADER_BYTE;
      rsp_in.byte_1      = HEADER_BYTE;
      rsp_in.byte_2      = job_data.servo_id;
      rsp_in.last_packet = job_data.last;
      if (job_data.is_load) begin
         rsp_in.packet_bytes = LOAD_BYTES;
         rsp_in.byte_3       = LOAD_LEN;
         rsp_in.byte_4       = LOAD_CMD;
         rsp_in.byte_5       = LOAD_PARAM;
         rsp_in.byte_6       = ~load_sum;
         rsp_in.byte_7       = 8'd0;
         rsp_in.byte_8       = 8'd0;
         rsp_in.byte_9       = 8'd0;
      end else begin
         rsp_in.packet_bytes = MOVE_BYTES;
         rsp_in.byte_3       = MOVE_LEN;
         rsp_in.byte_4       = cfg.move_cmd;
         rsp_in.byte_5       = job_data.position[7:0];
         rsp_in.byte_6       = job_data.position[15:8];
         rsp_in.byte_7       = job_data.move_time[7:0];
         rsp_in.byte_8       = job_data.move_time[15:8];
         rsp_in.byte_9       = ~move_sum;
      end
   end

   always_comb begin
      if (job_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/bus_servo_packet_scheduler.sv @@
// Top level of the bus servo packet scheduler.
//
//   channel  | direction | handshake            | word
//   req_     | in        | req_push / req_full  | req_type item
//   rsp_     | out       | rsp_pop / rsp_empty  | rsp_type packet
//   csr_     | in        | csr_valid/csr_ready  | index and data
//
// Register and update items are taken at once; a registration of an
// enabled slot then holds the input while its two jobs, a load and a move,
// are issued. A sending tick holds the input while the front end walks the
// table, issuing packets and stepping past stopped slots. Packets leave at
// one per cycle while rsp_pop is held, through a two-word job queue and the
// result register; a stalled rsp_pop backs up into the walk, then the input.
// Reset is synchronous and clears the slot count and enable flags at once;
// there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bus_servo_packet_scheduler
   import bsps_pkg::*;
#(
   parameter int unsigned SLOTS = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  req_type          req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   job_type q_in_data, q_out_data;
   logic    q_push, q_full, q_pop, q_empty;

   assign csr_ready = 1'b1;

   // Configuration register writes; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SERVO_ID_0:    cfg_in.servo_id[0]      = csr_wdata[7:0];
            CSR_SERVO_ID_1:    cfg_in.servo_id[1]      = csr_wdata[7:0];
            CSR_SERVO_ID_2:    cfg_in.servo_id[2]      = csr_wdata[7:0];
            CSR_SERVO_ID_3:    cfg_in.servo_id[3]      = csr_wdata[7:0];
            CSR_SEND_INTERVAL: cfg_in.send_interval    = csr_wdata;
            CSR_REFRESH_INTV:  cfg_in.refresh_interval = csr_wdata;
            CSR_MOVE_CMD:      cfg_in.move_cmd         = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.servo_id         <= '0;
         cfg_ff.send_interval    <= SEND_INTERVAL_RESET;
         cfg_ff.refresh_interval <= REFRESH_INTV_RESET;
         cfg_ff.move_cmd         <= MOVE_CMD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsps_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cfg      (cfg_ff),
      .job_push (q_push),
      .job_data (q_in_data),
      .job_full (q_full)
   );

   bsps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   bsps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (q_out_data),
      .job_empty (q_empty),
      .job_pop   (q_pop),
      .cfg       (cfg_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ test/bus_servo_packet_scheduler_test.sv @@
// Self-checking testbench for the bus servo packet scheduler.
`timescale 1ns / 1ps

module bus_servo_packet_scheduler_test;
   import bsps_pkg::*;

   localparam int SLOT_COUNT = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 45;
   localparam int PHASES = 8;

   // Framing of the servo bus packets, kept apart from the design's own copy.
   localparam logic [7:0] SYNC_BYTE = 8'h55;
   localparam logic [7:0] LOAD_OPCODE = 8'd31;
   localparam logic [7:0] LOAD_ARG = 8'd1;
   localparam logic [7:0] LOAD_LENGTH = 8'd4;
   localparam logic [7:0] MOVE_LENGTH = 8'd7;
   localparam logic [3:0] LOAD_SIZE = 4'd7;
   localparam logic [3:0] MOVE_SIZE = 4'd10;

   typedef struct packed {
      logic [2:0]  index;
      logic [15:0] value;
   } reg_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   req_type     req_data = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Words waiting to be offered and packets waiting to be seen.
   req_type       item_queue[$];
   rsp_type       packet_expect[$];
   reg_write_type write_queue[$];

   // Register copy used for prediction.
   logic [7:0]  cfg_servo_id[SLOT_COUNT];
   logic [15:0] cfg_send_gap = 16'd10;
   logic [15:0] cfg_refresh_gap = 16'd500;
   logic [7:0]  cfg_move_cmd = 8'd1;

   // Servo table and timing state as the scheduler should hold them.
   int          tbl_count = 0;
   logic        tbl_enabled[SLOT_COUNT];
   logic [15:0] tbl_position[SLOT_COUNT];
   logic [15:0] tbl_move_time[SLOT_COUNT];
   logic [31:0] sent_at = '0;
   logic [31:0] refreshed_at = '0;

   int cycles = 0;
   int mismatches = 0;
   int items_taken = 0;
   int packets_checked = 0;
   int sending_ticks = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit sender_eager = 1'b0;
   bit receiver_eager = 1'b0;
   bit hold_armed = 1'b0;
   bit hold_used = 1'b0;
   logic rsp_hold = 1'b0;
   logic [31:0] clock_ms = '0;

   bus_servo_packet_scheduler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
         cfg_servo_id[s] = '0;
         tbl_enabled[s] = 1'b0;
         tbl_position[s] = '0;
         tbl_move_time[s] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Builds one packet: header, id, length, command, parameters, checksum.
   function automatic rsp_type build_packet(input logic load, input logic [7:0] id,
                                            input logic [15:0] pos, input logic [15:0] mt);
      rsp_type    p;
      logic [7:0] sum;
      p = '0;
      p.byte_0 = SYNC_BYTE;
      p.byte_1 = SYNC_BYTE;
      p.byte_2 = id;
      if (load) begin
         p.packet_bytes = LOAD_SIZE;
         p.byte_3 = LOAD_LENGTH;
         p.byte_4 = LOAD_OPCODE;
         p.byte_5 = LOAD_ARG;
         sum = id + LOAD_LENGTH + LOAD_OPCODE + LOAD_ARG;
         p.byte_6 = ~sum;
      end else begin
         p.packet_bytes = MOVE_SIZE;
         p.byte_3 = MOVE_LENGTH;
         p.byte_4 = cfg_move_cmd;
         p.byte_5 = pos[7:0];
         p.byte_6 = pos[15:8];
         p.byte_7 = mt[7:0];
         p.byte_8 = mt[15:8];
         sum = id + MOVE_LENGTH + cfg_move_cmd + pos[7:0] + pos[15:8] + mt[7:0] + mt[15:8];
         p.byte_9 = ~sum;
      end
      return p;
   endfunction

   // Updates the servo table for one accepted word and queues the packets it causes.
   task automatic predict_packets(input req_type item);
      rsp_type burst[$];
      logic    do_refresh;
      do_refresh = 1'b0;
      case (cmd_type'(item.cmd))
         CMD_REGISTER: begin
            if (tbl_count < SLOT_COUNT) begin
               tbl_enabled[tbl_count] = item.enabled;
               tbl_position[tbl_count] = item.position;
               tbl_move_time[tbl_count] = item.move_time;
               if (item.enabled) begin
                  burst.push_back(build_packet(1'b1, cfg_servo_id[tbl_count], '0, '0));
                  burst.push_back(build_packet(1'b0, cfg_servo_id[tbl_count],
                                               item.position, item.move_time));
               end
               tbl_count++;
            end
         end
         CMD_UPDATE: begin
            if (int'(item.slot) < tbl_count) begin
               tbl_enabled[item.slot] = item.enabled;
               tbl_position[item.slot] = item.position;
               tbl_move_time[item.slot] = item.move_time;
            end
         end
         CMD_TICK: begin
            // Elapsed times wrap modulo 2^32.
            if (32'(item.now_ms - sent_at) >= {16'd0, cfg_send_gap}) begin
               sending_ticks++;
               sent_at = item.now_ms;
               if (32'(item.now_ms - refreshed_at) >= {16'd0, cfg_refresh_gap}) begin
                  refreshed_at = item.now_ms;
                  do_refresh = 1'b1;
               end
               for (int s = 0; s < tbl_count; s++) begin
                  if (tbl_enabled[s]) begin
                     if (do_refresh)
                        burst.push_back(build_packet(1'b1, cfg_servo_id[s], '0, '0));
                     burst.push_back(build_packet(1'b0, cfg_servo_id[s],
                                                  tbl_position[s], tbl_move_time[s]));
                  end
               end
            end
         end
         default: ;
      endcase
      if (burst.size() > 0) begin
         burst[burst.size() - 1].last_packet = 1'b1;
         foreach (burst[k]) packet_expect.push_back(burst[k]);
      end
   endtask

   function automatic logic [7:0] field_of(input rsp_type p, input int f);
      logic [84:0] bits;
      bits = p;
      if (f == 0) return {4'd0, p.packet_bytes};
      if (f == 11) return {7'd0, p.last_packet};
      return bits[88 - 8 * f -: 8];
   endfunction

   function automatic string field_name(input int f);
      if (f == 0) return "packet_bytes";
      if (f == 11) return "last_packet";
      return $sformatf("byte_%0d", f - 1);
   endfunction

   // Compares one popped packet with the oldest prediction.
   task automatic check_packet(input rsp_type got);
      rsp_type want;
      if (packet_expect.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("unexpected packet %h with nothing predicted", got);
         return;
      end
      want = packet_expect.pop_front();
      packets_checked++;
      for (int f = 0; f < 12; f++) begin
         if (field_of(want, f) !== field_of(got, f)) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("packet %0d %s: expected %h, got %h", packets_checked,
                        field_name(f), field_of(want, f), field_of(got, f));
         end
      end
   endtask

   function automatic int pick_gap(input bit eager);
      int r;
      r = $urandom_range(0, 99);
      if (eager || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type item_of(input cmd_type cmd, input logic [1:0] slot,
                                       input logic en, input logic [15:0] pos,
                                       input logic [15:0] mt, input logic [31:0] now);
      req_type it;
      it.cmd = cmd;
      it.slot = slot;
      it.enabled = en;
      it.position = pos;
      it.move_time = mt;
      it.now_ms = now;
      return it;
   endfunction

   // Mostly ticks that step past the send interval, with updates and noise between.
   function automatic req_type random_item();
      int      r;
      int      p;
      req_type it;
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 99);
      it = item_of(CMD_NONE, 2'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                   $urandom);
      if (r < 55) begin
         if (p < 65)
            clock_ms = clock_ms + cfg_send_gap + $urandom_range(0, 3);
         else if (p < 85)
            clock_ms = clock_ms + $urandom_range(0, cfg_send_gap);
         else
            clock_ms = $urandom;
         it.cmd = CMD_TICK;
         it.now_ms = clock_ms;
      end else if (r < 85) begin
         it.cmd = CMD_UPDATE;
         it.enabled = ($urandom_range(0, 99) < 80);
      end else if (r < 93) begin
         it.cmd = CMD_REGISTER;
      end
      return it;
   endfunction

   // Request driver: offers queued words and predicts each accepted one.
   always @(posedge clock) begin : feeder
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_packets(req_data);
            items_taken++;
            gap_left = pick_gap(sender_eager);
         end
         if (!(req_push && req_full)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (item_queue.size() > 0) begin
               req_push <= 1'b1;
               req_data <= item_queue.pop_front();
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Response monitor: pops packets with random stalls and checks each one.
   always @(posedge clock) begin : collector
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_packet(rsp_data);
            stall_left = pick_gap(receiver_eager);
         end
         if (rsp_hold) begin
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // One long receiver hold-off so that the scheduler backs up into its input.
   always @(posedge clock) begin : backpressure
      if (reset) begin
         rsp_hold <= 1'b0;
      end else if (hold_armed && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_hold <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left--;
      end else if (hold_left == 1) begin
         hold_left = 0;
         rsp_hold <= 1'b0;
      end
   end

   // Register write channel; the prediction copy follows each accepted write.
   always @(posedge clock) begin : reg_writer
      reg_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SERVO_ID_0, CSR_SERVO_ID_1, CSR_SERVO_ID_2, CSR_SERVO_ID_3:
                  cfg_servo_id[csr_index] = csr_wdata[7:0];
               CSR_SEND_INTERVAL: cfg_send_gap = csr_wdata;
               CSR_REFRESH_INTV: cfg_refresh_gap = csr_wdata;
               CSR_MOVE_CMD: cfg_move_cmd = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (!(csr_valid && !csr_ready)) begin
            if (write_queue.size() > 0) begin
               w = write_queue.pop_front();
               csr_valid <= 1'b1;
               csr_index <= w.index;
               csr_wdata <= w.value;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Waits until every word is taken and every packet seen, then lets the block settle.
   task automatic wait_idle();
      do @(negedge clock);
      while (item_queue.size() != 0 || req_push || packet_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_registers(input int ph);
      logic [15:0] send_gap;
      logic [15:0] refresh_gap;
      logic [15:0] move_cmd;
      case (ph)
         0: begin
            send_gap = 16'd1;
            refresh_gap = 16'd1;
            move_cmd = 16'd0;
         end
         1: begin
            send_gap = 16'd0;
            refresh_gap = 16'd0;
            move_cmd = 16'd255;
         end
         2: begin
            send_gap = 16'hffff;
            refresh_gap = 16'hffff;
            move_cmd = 16'($urandom_range(0, 255));
         end
         default: begin
            send_gap = 16'($urandom_range(1, 30));
            refresh_gap = 16'($urandom_range(1, 200));
            move_cmd = 16'($urandom_range(0, 255));
         end
      endcase
      write_queue.push_back('{CSR_SERVO_ID_0, (ph == 0) ? 16'd0 : 16'($urandom_range(0, 255))});
      write_queue.push_back('{CSR_SERVO_ID_1, (ph == 0) ? 16'd253 : 16'($urandom_range(0, 255))});
      write_queue.push_back('{CSR_SERVO_ID_2, (ph == 0) ? 16'd255 : 16'($urandom_range(0, 255))});
      write_queue.push_back('{CSR_SERVO_ID_3, (ph == 0) ? 16'd1 : 16'($urandom_range(0, 255))});
      write_queue.push_back('{CSR_SEND_INTERVAL, send_gap});
      write_queue.push_back('{CSR_REFRESH_INTV, refresh_gap});
      write_queue.push_back('{CSR_MOVE_CMD, move_cmd});
      do @(negedge clock);
      while (write_queue.size() != 0 || csr_valid);
   endtask

   initial begin : stimulus
      do @(negedge clock);
      while (reset);

      // Directed words under the reset register values: early ticks, ignored
      // words, a partly filled table, a full table, wrapping time and refresh.
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'd5));
      item_queue.push_back(item_of(CMD_NONE, 2'd3, 1'b1, 16'hffff, 16'hffff, 32'hffffffff));
      item_queue.push_back(item_of(CMD_UPDATE, 2'd3, 1'b1, 16'h1111, 16'h2222, '0));
      item_queue.push_back(item_of(CMD_REGISTER, 2'd0, 1'b1, 16'h0000, 16'h0000, '0));
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'd10));
      item_queue.push_back(item_of(CMD_REGISTER, 2'd0, 1'b0, 16'hffff, 16'hffff, '0));
      item_queue.push_back(item_of(CMD_REGISTER, 2'd0, 1'b1, 16'hffff, 16'hffff, '0));
      item_queue.push_back(item_of(CMD_REGISTER, 2'd0, 1'b1, 16'h1234, 16'hedcb, '0));
      item_queue.push_back(item_of(CMD_REGISTER, 2'd2, 1'b1, 16'h5a5a, 16'ha5a5, '0));
      item_queue.push_back(item_of(CMD_UPDATE, 2'd1, 1'b1, 16'h00ff, 16'hff00, '0));
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'd19));
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'd500));
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'hffffffff));
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'd8));
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'd9));
      for (int s = 0; s < SLOT_COUNT; s++)
         item_queue.push_back(item_of(CMD_UPDATE, 2'(s), 1'b0, 16'($urandom), 16'($urandom), '0));
      // With every slot stopped, a sending tick still moves the refresh time.
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'd2000));
      item_queue.push_back(item_of(CMD_UPDATE, 2'd2, 1'b1, 16'h8000, 16'h0001, '0));
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'd2009));
      item_queue.push_back(item_of(CMD_TICK, 2'd0, 1'b0, '0, '0, 32'd2010));
      clock_ms = 32'd2010;

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         program_registers(ph);
         sender_eager = (ph == 4) || ($urandom_range(0, 3) == 0);
         receiver_eager = (ph != 4) && ($urandom_range(0, 3) == 0);
         hold_armed = (ph == 4);
         repeat (PHASE_ITEMS) item_queue.push_back(random_item());
      end
      wait_idle();

      $display("Covered %0d words, %0d of them sending ticks, and checked %0d packets",
               items_taken, sending_ticks, packets_checked);
      $display("over %0d register settings, with one long receiver hold-off.", PHASES + 1);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
